// ----- hdl/trmt_pkg.sv -----
// ----------------------------------------------------------------------------
// trmt_pkg
// Types, widths and codes shared by the timed range match table.
// ----------------------------------------------------------------------------
package trmt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NUM_W       = 32;
  localparam int TIME_W      = 31;
  localparam int LIM_W       = 33;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_NOMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ABS   = 2'd1,
    MODE_AGE   = 2'd2
  } mode_e;

  typedef enum logic {
    REG_LIST_MODE  = 1'b0,
    REG_AGE_OFFSET = 1'b1
  } reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  typedef struct packed {
    logic [NUM_W-1:0]  low;
    logic [NUM_W-1:0]  high;
    logic [TIME_W-1:0] expiry;
    logic              timed;
  } entry_t;

  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_pos;
  } ring_ctl_t;

endpackage

// ----- hdl/trmt_cell.sv -----
// ----------------------------------------------------------------------------
// trmt_cell
// One table slot of the ring: load a new entry, take the neighbor's entry
// on a shift, or hold.
// ----------------------------------------------------------------------------
module trmt_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic            load_i,
  input  trmt_pkg::entry_t load_data_i,
  input  trmt_pkg::entry_t next_data_i,
  output trmt_pkg::entry_t data_o
);
  import trmt_pkg::*;

  entry_t data_q;
  entry_t data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hdl/trmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// trmt_ctrl
// Sequencer of the table: append and clear, and the walk that evaluates the
// head cell, drops expired or removed entries and requeues the kept ones.
// ----------------------------------------------------------------------------
module trmt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   action_i,
  input  logic [trmt_pkg::NUM_W-1:0]   range_low_i,
  input  logic [trmt_pkg::NUM_W-1:0]   range_high_i,
  input  logic                         has_expiry_i,
  input  logic [trmt_pkg::TIME_W-1:0]  expiry_time_i,
  input  logic [trmt_pkg::NUM_W-1:0]   query_number_i,
  input  logic [trmt_pkg::TIME_W-1:0]  now_time_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  input  trmt_pkg::entry_t             head_i,
  output trmt_pkg::ring_ctl_t          ring_o,
  output trmt_pkg::entry_t             wr_data_o,
  output logic                         busy_o,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [1:0]                   status_o,
  output logic [trmt_pkg::CNT_W-1:0]   entry_count_o,
  output logic [trmt_pkg::CNT_W-1:0]   expired_count_o
);
  import trmt_pkg::*;

  state_e             state_q, state_d;
  logic [1:0]         mode_q;
  logic [31:0]        offset_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   kept_q, kept_d;
  logic [CNT_W-1:0]   exp_q, exp_d;
  logic               found_q, found_d;
  logic               remove_q, remove_d;
  logic               timed_q, timed_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic signed [LIM_W-1:0] limit_q, limit_d;

  logic               done_q, done_d;
  logic               hit_q, hit_d;
  logic [1:0]         status_q, status_d;
  logic [CNT_W-1:0]   cnt_out_q, cnt_out_d;
  logic [CNT_W-1:0]   exp_out_q, exp_out_d;

  logic               accept;
  logic               holds;
  logic               expd;
  logic               drop;
  logic               found_now;
  logic [CNT_W-1:0]   tail_pos;
  logic               last;
  logic               table_full;

  assign accept     = start_i && (state_q == ST_IDLE);
  assign holds      = (head_i.low <= num_q) && (head_i.high >= num_q);
  assign expd       = timed_q && head_i.timed &&
                      ($signed({2'b00, head_i.expiry}) < limit_q);
  assign found_now  = !found_q && holds && (remove_q || !expd);
  assign drop       = !found_q && (remove_q ? holds : expd);
  assign tail_pos   = rem_q + kept_q - CNT_W'(1);
  assign last       = (rem_q == CNT_W'(1));
  assign table_full = (count_q >= CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_LOOKUP || action_i == ACT_REMOVE) &&
            count_q != '0) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    rem_d     = rem_q;
    kept_d    = kept_q;
    exp_d     = exp_q;
    found_d   = found_q;
    remove_d  = remove_q;
    timed_d   = timed_q;
    num_d     = num_q;
    limit_d   = limit_q;
    done_d    = 1'b0;
    hit_d     = hit_q;
    status_d  = status_q;
    cnt_out_d = cnt_out_q;
    exp_out_d = exp_out_q;
    ring_o    = '0;
    wr_data_o = head_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          num_d    = query_number_i;
          remove_d = (action_i == ACT_REMOVE);
          timed_d  = (action_i == ACT_LOOKUP) &&
                     (mode_q == MODE_ABS || mode_q == MODE_AGE);
          limit_d  = (mode_q == MODE_AGE) ?
                     $signed({2'b00, now_time_i}) + $signed({offset_q[31], offset_q}) :
                     $signed({2'b00, now_time_i});
          rem_d    = count_q;
          kept_d   = '0;
          exp_d    = '0;
          found_d  = 1'b0;
          hit_d    = 1'b0;
          status_d = STS_OK;
          exp_out_d = '0;
          case (action_i)
            ACT_ADD: begin
              done_d = 1'b1;
              if (table_full) begin
                status_d = STS_FULL;
              end else begin
                ring_o.wr_en  = 1'b1;
                ring_o.wr_pos = count_q[IDX_W-1:0];
                wr_data_o.low    = range_low_i;
                wr_data_o.high   = range_high_i;
                wr_data_o.expiry = expiry_time_i;
                wr_data_o.timed  = has_expiry_i;
                count_d = count_q + CNT_W'(1);
              end
              cnt_out_d = count_d;
            end
            ACT_CLEAR: begin
              done_d    = 1'b1;
              count_d   = '0;
              cnt_out_d = '0;
            end
            default: begin
              if (count_q == '0) begin
                done_d    = 1'b1;
                status_d  = STS_NOMATCH;
                cnt_out_d = '0;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        ring_o.shift  = 1'b1;
        ring_o.wr_en  = !drop;
        ring_o.wr_pos = tail_pos[IDX_W-1:0];
        rem_d   = rem_q - CNT_W'(1);
        kept_d  = drop ? kept_q : kept_q + CNT_W'(1);
        exp_d   = (drop && !remove_q) ? exp_q + CNT_W'(1) : exp_q;
        found_d = found_q || found_now;
        if (last) begin
          done_d    = 1'b1;
          count_d   = kept_d;
          hit_d     = found_d;
          status_d  = found_d ? STS_OK : STS_NOMATCH;
          cnt_out_d = kept_d;
          exp_out_d = exp_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      mode_q   <= MODE_PLAIN;
      offset_q <= '0;
      done_q   <= 1'b0;
      rem_q    <= '0;
      kept_q   <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      rem_q   <= rem_d;
      kept_q  <= kept_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LIST_MODE:  mode_q   <= cfg_wdata_i[1:0];
          REG_AGE_OFFSET: offset_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q     <= exp_d;
    remove_q  <= remove_d;
    timed_q   <= timed_d;
    num_q     <= num_d;
    limit_q   <= limit_d;
    hit_q     <= hit_d;
    status_q  <= status_d;
    cnt_out_q <= cnt_out_d;
    exp_out_q <= exp_out_d;
  end

  assign busy_o          = (state_q == ST_WALK);
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign status_o        = status_q;
  assign entry_count_o   = cnt_out_q;
  assign expired_count_o = exp_out_q;

endmodule

// ----- hdl/timed_range_match_table.sv -----
// ----------------------------------------------------------------------------
// timed_range_match_table
// Ordered table of inclusive ranges with optional expiry, held in a ring of
// cells that rotates past one compare unit at its head.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; its result is shown
// for one cycle with done_o and cannot be held off. Add and clear, and lookup
// or remove on an empty table, give their result in the cycle after the item is
// taken and never raise busy_o. Lookup and remove rotate every held entry once
// past the head compare unit, one entry per cycle, so they keep busy_o high
// while the walk lasts and give their result when the last held entry has
// passed the head. Configuration writes belong in idle time only.
module timed_range_match_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   action_i,
  input  logic [trmt_pkg::NUM_W-1:0]   range_low_i,
  input  logic [trmt_pkg::NUM_W-1:0]   range_high_i,
  input  logic                         has_expiry_i,
  input  logic [trmt_pkg::TIME_W-1:0]  expiry_time_i,
  input  logic [trmt_pkg::NUM_W-1:0]   query_number_i,
  input  logic [trmt_pkg::TIME_W-1:0]  now_time_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic [1:0]                   status_o,
  output logic [trmt_pkg::CNT_W-1:0]   entry_count_o,
  output logic [trmt_pkg::CNT_W-1:0]   expired_count_o
);
  import trmt_pkg::*;

  ring_ctl_t ring;
  entry_t    wr_data;
  entry_t    cells [TABLE_DEPTH];

  trmt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .action_i        (action_i),
    .range_low_i     (range_low_i),
    .range_high_i    (range_high_i),
    .has_expiry_i    (has_expiry_i),
    .expiry_time_i   (expiry_time_i),
    .query_number_i  (query_number_i),
    .now_time_i      (now_time_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .head_i          (cells[0]),
    .ring_o          (ring),
    .wr_data_o       (wr_data),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .expired_count_o (expired_count_o)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int Nxt = (i + 1) % TABLE_DEPTH;
    logic load;

    assign load = ring.wr_en && (ring.wr_pos == IDX_W'(i));

    trmt_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (ring.shift),
      .load_i      (load),
      .load_data_i (wr_data),
      .next_data_i (cells[Nxt]),
      .data_o      (cells[i])
    );
  end

endmodule

// ----- tb/timed_range_match_table_tb.sv -----
// ----------------------------------------------------------------------------
// timed_range_match_table_tb
// Self-checking bench for the timed range match table. A cycle-free model of
// the ordered table, with expiry and compaction, predicts hit, status, entry
// count and expired count for each item taken; every done_o strobe is checked
// against the oldest prediction. Directed tests cover the bounds of the
// fields, each table mode and each action. Random phases, some first filling
// the table past full, mix all four actions under bursty start_i.
// ----------------------------------------------------------------------------
module timed_range_match_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trmt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 85;
  localparam logic [NUM_W-1:0]  NUM_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    act_e              act;
    logic [NUM_W-1:0]  lo;
    logic [NUM_W-1:0]  hi;
    logic              timed;
    logic [TIME_W-1:0] exp;
    logic [NUM_W-1:0]  num;
    logic [TIME_W-1:0] now;
  } table_op_t;

  typedef struct {
    logic             hit;
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] expired;
  } outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         action_i = ACT_ADD;
  logic [NUM_W-1:0]   range_low_i = '0;
  logic [NUM_W-1:0]   range_high_i = '0;
  logic               has_expiry_i = 1'b0;
  logic [TIME_W-1:0]  expiry_time_i = '0;
  logic [NUM_W-1:0]   query_number_i = '0;
  logic [TIME_W-1:0]  now_time_i = '0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = REG_LIST_MODE;
  logic [31:0]        cfg_wdata_i = '0;
  logic               done_o;
  logic               hit_o;
  logic [1:0]         status_o;
  logic [CNT_W-1:0]   entry_count_o;
  logic [CNT_W-1:0]   expired_count_o;

  logic [NUM_W-1:0]   held_lows  [TABLE_DEPTH];
  logic [NUM_W-1:0]   held_highs [TABLE_DEPTH];
  logic [TIME_W-1:0]  held_exps  [TABLE_DEPTH];
  logic               held_timed [TABLE_DEPTH];
  int                 held_count = 0;
  logic [1:0]         cur_mode = MODE_PLAIN;
  logic signed [31:0] cur_offset = '0;

  outcome_t           pending_outcomes[$];
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 burst_left = 0;
  bit                 gaps_on = 1'b1;
  logic [NUM_W-1:0]   num_base = '0;
  logic [TIME_W-1:0]  time_base = '0;

  always #1 clk_i = ~clk_i;

  timed_range_match_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .has_expiry_i   (has_expiry_i),
    .expiry_time_i  (expiry_time_i),
    .query_number_i (query_number_i),
    .now_time_i     (now_time_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .expired_count_o(expired_count_o)
  );

  // close the gap left by entry pos
  function automatic void squeeze_out(int pos);
    for (int k = pos; k + 1 < held_count; k++) begin
      held_lows[k]  = held_lows[k+1];
      held_highs[k] = held_highs[k+1];
      held_exps[k]  = held_exps[k+1];
      held_timed[k] = held_timed[k+1];
    end
    held_count--;
  endfunction

  function automatic outcome_t apply_op(table_op_t op);
    outcome_t res;
    longint   lim;
    int       j;
    int       dropped;
    bit       timed_mode;
    res.hit    = 1'b0;
    res.status = STS_OK;
    dropped    = 0;
    case (op.act)
      ACT_ADD: begin
        if (held_count >= TABLE_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          held_lows[held_count]  = op.lo;
          held_highs[held_count] = op.hi;
          held_exps[held_count]  = op.exp;
          held_timed[held_count] = op.timed;
          held_count++;
        end
      end
      ACT_LOOKUP: begin
        lim = (cur_mode == MODE_AGE) ? longint'(op.now) + longint'(cur_offset)
                                     : longint'(op.now);
        timed_mode = (cur_mode == MODE_ABS) || (cur_mode == MODE_AGE);
        j = 0;
        while (j < held_count) begin
          if (timed_mode && held_timed[j] && longint'(held_exps[j]) < lim) begin
            squeeze_out(j);
            dropped++;
          end else if (held_lows[j] <= op.num && held_highs[j] >= op.num) begin
            res.hit = 1'b1;
            break;
          end else begin
            j++;
          end
        end
        if (!res.hit) res.status = STS_NOMATCH;
      end
      ACT_REMOVE: begin
        for (j = 0; j < held_count; j++) begin
          if (held_lows[j] <= op.num && held_highs[j] >= op.num) begin
            squeeze_out(j);
            res.hit = 1'b1;
            break;
          end
        end
        if (!res.hit) res.status = STS_NOMATCH;
      end
      default: begin
        held_count = 0;
      end
    endcase
    res.count   = CNT_W'(held_count);
    res.expired = CNT_W'(dropped);
    return res;
  endfunction

  function automatic table_op_t op_of(act_e act, logic [NUM_W-1:0] lo,
                                      logic [NUM_W-1:0] hi, logic timed,
                                      logic [TIME_W-1:0] exp,
                                      logic [NUM_W-1:0] num,
                                      logic [TIME_W-1:0] now);
    table_op_t op;
    op.act   = act;
    op.lo    = lo;
    op.hi    = hi;
    op.timed = timed;
    op.exp   = exp;
    op.num   = num;
    op.now   = now;
    return op;
  endfunction

  function automatic logic [NUM_W-1:0] pick_number();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return num_base + $urandom_range(0, 63);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    if ($urandom_range(0, 9) == 0) return TIME_W'($urandom);
    return time_base + TIME_W'($urandom_range(0, 100));
  endfunction

  function automatic table_op_t random_op(act_e act);
    table_op_t op;
    int        r;
    op.act = act;
    op.lo  = pick_number();
    r      = $urandom_range(0, 19);
    if (r == 0) op.hi = op.lo - 1 - $urandom_range(0, 5);
    else if (r < 3) op.hi = pick_number();
    else op.hi = op.lo + $urandom_range(0, 12);
    op.timed = ($urandom_range(0, 9) < 6);
    op.exp   = pick_time();
    op.num   = pick_number();
    op.now   = pick_time();
    return op;
  endfunction

  function automatic act_e pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ACT_ADD;
    if (r < 75) return ACT_LOOKUP;
    if (r < 93) return ACT_REMOVE;
    return ACT_CLEAR;
  endfunction

  task automatic send_item(table_op_t op);
    start_i        <= 1'b1;
    action_i       <= op.act;
    range_low_i    <= op.lo;
    range_high_i   <= op.hi;
    has_expiry_i   <= op.timed;
    expiry_time_i  <= op.exp;
    query_number_i <= op.num;
    now_time_i     <= op.now;
    do @(posedge clk_i); while (busy_o);
    pending_outcomes.push_back(apply_op(op));
    if (burst_left > 0) begin
      burst_left--;
    end else if (gaps_on) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // hold off until every predicted result has been seen
  task automatic wait_table_quiet();
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_LIST_MODE) cur_mode = data[1:0];
    else cur_offset = data;
    @(posedge clk_i);
  endtask

  task automatic test_plain_table();
    send_item(op_of(ACT_ADD, '0, '0, 1'b1, '0, NUM_MAX, TIME_MAX));
    send_item(op_of(ACT_ADD, NUM_MAX, NUM_MAX, 1'b0, TIME_MAX, '0, '0));
    send_item(op_of(ACT_ADD, 32'd10, 32'd3, 1'b1, 31'd5, 32'd7, '0));
    send_item(op_of(ACT_ADD, 32'd20, 32'd30, 1'b1, TIME_MAX, '0, TIME_MAX));
    send_item(op_of(ACT_LOOKUP, NUM_MAX, '0, 1'b1, TIME_MAX, '0, TIME_MAX));
    send_item(op_of(ACT_LOOKUP, '0, NUM_MAX, 1'b0, '0, NUM_MAX, TIME_MAX));
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, 32'd5, TIME_MAX));
    send_item(op_of(ACT_REMOVE, '0, '0, 1'b0, '0, 32'd7, '0));
    send_item(op_of(ACT_REMOVE, '0, '0, 1'b0, '0, 32'd25, '0));
    wait_table_quiet();
    write_reg(REG_LIST_MODE, 32'hFFFF_FFFF);
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, 32'd5, TIME_MAX));
    wait_table_quiet();
  endtask

  task automatic test_absolute_expiry();
    write_reg(REG_LIST_MODE, {30'h2AAA_AAAA, MODE_ABS});
    send_item(op_of(ACT_ADD, 32'd40, 32'd50, 1'b1, 31'd100, '0, '0));
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, 32'd45, 31'd5));
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, 32'd45, TIME_MAX));
    send_item(op_of(ACT_REMOVE, '0, '0, 1'b0, '0, NUM_MAX, '0));
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, '0, '0));
    send_item(op_of(ACT_ADD, '0, NUM_MAX, 1'b1, TIME_MAX, '0, '0));
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, 32'd1, TIME_MAX));
    wait_table_quiet();
  endtask

  task automatic test_age_expiry();
    write_reg(REG_LIST_MODE, {30'h0, MODE_AGE});
    write_reg(REG_AGE_OFFSET, 32'h8000_0000);
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, 32'd1, TIME_MAX));
    wait_table_quiet();
    write_reg(REG_AGE_OFFSET, 32'h7FFF_FFFF);
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, 32'd1, '0));
    send_item(op_of(ACT_CLEAR, NUM_MAX, NUM_MAX, 1'b1, TIME_MAX, NUM_MAX, TIME_MAX));
    send_item(op_of(ACT_LOOKUP, '0, '0, 1'b0, '0, '0, '0));
    send_item(op_of(ACT_REMOVE, '0, '0, 1'b0, '0, '0, '0));
    wait_table_quiet();
  endtask

  task automatic test_random_traffic();
    logic [31:0] data;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_table_quiet();
      data = $urandom;
      case (phase % 4)
        0:       data[1:0] = MODE_AGE;
        1:       data[1:0] = MODE_ABS;
        2:       data[1:0] = MODE_PLAIN;
        default: data[1:0] = 2'd3;
      endcase
      write_reg(REG_LIST_MODE, data);
      case ($urandom_range(0, 4))
        0:       data = '0;
        1:       data = 32'h8000_0000;
        2:       data = 32'h7FFF_FFFF;
        3:       data = int'($urandom_range(0, 300)) - 150;
        default: data = $urandom;
      endcase
      write_reg(REG_AGE_OFFSET, data);
      case ($urandom_range(0, 2))
        0:       num_base = '0;
        1:       num_base = 32'hFFFF_FFC0;
        default: num_base = $urandom;
      endcase
      case ($urandom_range(0, 2))
        0:       time_base = '0;
        1:       time_base = 31'h7FFF_FF00;
        default: time_base = TIME_W'($urandom);
      endcase
      gaps_on = (phase % 3 != 0);
      send_item(random_op(ACT_CLEAR));
      // fill past full
      if (phase % 3 == 1) begin
        repeat (TABLE_DEPTH + 2) send_item(random_op(ACT_ADD));
      end
      repeat (PHASE_ITEMS) send_item(random_op(pick_action()));
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result with no item pending");
      end else begin
        want = pending_outcomes.pop_front();
        if (hit_o !== want.hit || status_o !== want.status ||
            entry_count_o !== want.count || expired_count_o !== want.expired) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0d status=%0d count=%0d expired=%0d, got hit=%0d status=%0d count=%0d expired=%0d",
                     want.hit, want.status, want.count, want.expired,
                     hit_o, status_o, entry_count_o, expired_count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_table();
    test_absolute_expiry();
    test_age_expiry();
    test_random_traffic();
    wait_table_quiet();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/trmt_pkg.sv
hdl/trmt_cell.sv
hdl/trmt_ctrl.sv
hdl/timed_range_match_table.sv
tb/timed_range_match_table_tb.sv
